/* rtl/core/owd_delay_congestion_threshold_unit_assert.svh */
// assertion macros shared by the owd delay threshold rtl
`ifndef OWD_DELAY_CONGESTION_THRESHOLD_UNIT_ASSERT_SVH
`define OWD_DELAY_CONGESTION_THRESHOLD_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define ODCT_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("odct assertion failed");

// next-cycle implication, off during reset
`define ODCT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("odct assertion failed");

`endif

/* rtl/core/odct_pkg.sv */
// types and constants of the owd delay threshold block
`timescale 1ns / 1ps
`default_nettype none
package odct_pkg;

  localparam logic OP_ACK  = 1'b0;
  localparam logic OP_LOSS = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLLOVER     = 2'd1;

  localparam logic [15:0] SEGMENT_SIZE_RST = 16'd536;
  localparam logic [15:0] ROLLOVER_RST     = 16'd60;

  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic        opcode;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic        rtt_positive;
    logic [31:0] now_seconds;
    logic [31:0] bytes_in_flight;
    logic [31:0] old_threshold;
  } odct_in_t;

  typedef struct packed {
    logic [31:0] new_threshold;
    logic [31:0] max_queue_delay;
    logic [31:0] base_delay;
  } odct_out_t;

endpackage
`default_nettype wire

/* rtl/core/odct_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module odct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/odct_div.sv */
// restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
`include "owd_delay_congestion_threshold_unit_assert.svh"
module odct_div
  import odct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [32:0] divisor,
  output logic             done,
  output logic      [63:0] quotient
);

  localparam int CW = $clog2(DIV_STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [32:0]   rem;
  logic [63:0]   dvd;
  logic [32:0]   dsr;
  logic [33:0]   rem_sh;
  logic          qbit;
  logic [32:0]   rem_next;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh   = {rem, dvd[63]};
    qbit     = rem_sh >= {1'b0, dsr};
    rem_next = qbit ? 33'(rem_sh - {1'b0, dsr}) : rem_sh[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[62:0], qbit};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

  `ODCT_ASSERT_NEXT(a_start_busy, clk, rst, start, busy)
  `ODCT_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `ODCT_ASSERT_NEXT(a_busy_runs, clk, rst, busy && !start, busy || done)

endmodule
`default_nettype wire

/* rtl/core/owd_delay_congestion_threshold_unit.sv */
// top level: one-way delay base tracking and loss threshold unit
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    odct_in_t  in_data
//  out      output     out_valid / out_stall  odct_out_t out_data
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data (16 bits)
//
// ack without a usable sample goes straight to the finish state; an ack with a sample passes
// through push, a sweep over the two window rams for min and max, queue delay and finish
// loss event: the short paths go straight to finish, else multiply, the 64-step divider, clamp
// one item at a time: in_stall is high from acceptance until the result is loaded
// rst is synchronous; the windows start empty through their fill counts
// a stalled result holds in the output register while the next item may be taken
`timescale 1ns / 1ps
`default_nettype none
`include "owd_delay_congestion_threshold_unit_assert.svh"
module owd_delay_congestion_threshold_unit
  import odct_pkg::*;
#(
  parameter int BASE_LEN   = 10,
  parameter int FILTER_LEN = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire odct_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output odct_out_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  localparam int BCAP    = BASE_LEN - 1;
  localparam int FCAP    = FILTER_LEN - 1;
  localparam int BAW     = (BCAP > 1) ? $clog2(BCAP) : 1;
  localparam int FAW     = (FCAP > 1) ? $clog2(FCAP) : 1;
  localparam int BUW     = $clog2(BCAP + 1);
  localparam int FUW     = $clog2(FCAP + 1);
  localparam int SWEEP_N = (BCAP > FCAP) ? BCAP : FCAP;
  localparam int SW      = $clog2(SWEEP_N + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_SWEEP, S_QDLY, S_LOSS, S_MUL, S_DIVGO, S_DIVWAIT, S_CLAMP, S_FINISH
  } state_t;

  state_t      state;
  odct_in_t    item;
  logic [15:0] segment_size;
  logic [15:0] rollover_seconds;

  logic [BUW-1:0] base_used;
  logic [BAW-1:0] base_head;
  logic [BAW-1:0] base_newest;
  logic [31:0]    base_last;
  logic [FUW-1:0] recent_used;
  logic [FAW-1:0] recent_head;
  logic [31:0]    base_min;
  logic [31:0]    recent_min;
  logic [31:0]    recent_max;
  logic [31:0]    largest_qd;
  logic [31:0]    last_rollover;
  logic           sample_valid;
  logic [SW-1:0]  sweep_idx;
  logic [31:0]    dreg;
  logic [63:0]    product;
  logic [31:0]    thr;

  logic [31:0]    owd;
  logic           r_full;
  logic           r_we;
  logic [FAW-1:0] r_waddr;
  logic [31:0]    r_rdata;
  logic           b_full;
  logic           b_push;
  logic           b_lower;
  logic           b_we;
  logic [BAW-1:0] b_waddr;
  logic [31:0]    b_rdata;
  logic [SW-1:0]  sweep_k;
  logic [31:0]    floor2;
  logic [31:0]    half_bif;
  logic [31:0]    d_loss;
  logic [31:0]    qdly;
  logic [31:0]    q_clamped;
  logic           div_start;
  logic           div_done;
  logic [63:0]    div_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign div_start = (state == S_DIVGO);

  always_comb begin
    owd     = item.ts_value - item.ts_echo;
    r_full  = recent_used == FUW'(FCAP);
    r_waddr = r_full ? recent_head : recent_used[FAW-1:0];
    r_we    = (state == S_PUSH);
    b_full  = base_used == BUW'(BCAP);
    // an empty history always opens its first slot
    b_push  = (base_used == '0) ||
              ((item.now_seconds - last_rollover) > {16'b0, rollover_seconds});
    b_lower = !b_push && (owd < base_last);
    b_waddr = b_push ? (b_full ? base_head : base_used[BAW-1:0]) : base_newest;
    b_we    = (state == S_PUSH) && (b_push || b_lower);
    sweep_k = sweep_idx - SW'(1);
    floor2  = {15'b0, segment_size, 1'b0};
    half_bif = {1'b0, item.bytes_in_flight[31:1]};
    d_loss  = recent_max - base_min;
    qdly    = recent_min - base_min;
    q_clamped = (div_q > {32'b0, item.old_threshold}) ? item.old_threshold : div_q[31:0];
  end

  odct_ram #(.WIDTH(32), .DEPTH(FCAP)) u_recent_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (owd),
    .raddr (sweep_idx[FAW-1:0]),
    .rdata (r_rdata)
  );

  odct_ram #(.WIDTH(32), .DEPTH(BCAP)) u_base_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (owd),
    .raddr (sweep_idx[BAW-1:0]),
    .rdata (b_rdata)
  );

  odct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  ({dreg, 1'b0}),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      segment_size     <= SEGMENT_SIZE_RST;
      rollover_seconds <= ROLLOVER_RST;
      base_used        <= '0;
      base_head        <= '0;
      base_newest      <= '0;
      recent_used      <= '0;
      recent_head      <= '0;
      base_min         <= '1;
      recent_min       <= '1;
      recent_max       <= '0;
      largest_qd       <= '0;
      last_rollover    <= '0;
      sample_valid     <= 1'b0;
      sweep_idx        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SEGMENT_SIZE: segment_size     <= cfg_data;
          REG_ROLLOVER:     rollover_seconds <= cfg_data;
          default: ;
        endcase
      end

      // the finish state reloads the register itself
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            thr  <= '0;
            if (in_data.opcode == OP_ACK) begin
              sample_valid <= (in_data.ts_value != '0) && (in_data.ts_echo != '0);
              if ((in_data.ts_value != '0) && (in_data.ts_echo != '0) &&
                  in_data.rtt_positive) begin
                state <= S_PUSH;
              end else begin
                state <= S_FINISH;
              end
            end else begin
              state <= S_LOSS;
            end
          end
        end
        S_PUSH: begin
          if (r_full) begin
            recent_head <= (recent_head == FAW'(FCAP - 1)) ? '0 : recent_head + FAW'(1);
          end else begin
            recent_used <= recent_used + FUW'(1);
          end
          if (b_push) begin
            base_newest <= b_waddr;
            base_last   <= owd;
            if (base_used != '0) begin
              last_rollover <= item.now_seconds;
            end
            if (b_full) begin
              base_head <= (base_head == BAW'(BCAP - 1)) ? '0 : base_head + BAW'(1);
            end else begin
              base_used <= base_used + BUW'(1);
            end
          end else if (b_lower) begin
            base_last <= owd;
          end
          base_min   <= '1;
          recent_min <= '1;
          recent_max <= '0;
          sweep_idx  <= '0;
          state      <= S_SWEEP;
        end
        S_SWEEP: begin
          // read data belongs to the address of the previous sweep step
          if (sweep_idx != '0) begin
            if (sweep_k < SW'(base_used)) begin
              if (b_rdata < base_min) begin
                base_min <= b_rdata;
              end
            end
            if (sweep_k < SW'(recent_used)) begin
              if (r_rdata < recent_min) begin
                recent_min <= r_rdata;
              end
              if (r_rdata > recent_max) begin
                recent_max <= r_rdata;
              end
            end
          end
          if (sweep_idx == SW'(SWEEP_N)) begin
            state <= S_QDLY;
          end else begin
            sweep_idx <= sweep_idx + SW'(1);
          end
        end
        S_QDLY: begin
          if (qdly > largest_qd) begin
            largest_qd <= qdly;
          end
          state <= S_FINISH;
        end
        S_LOSS: begin
          if (!sample_valid || (largest_qd == '0)) begin
            thr   <= (half_bif > floor2) ? half_bif : floor2;
            state <= S_FINISH;
          end else if (d_loss == '0) begin
            thr   <= item.old_threshold;
            state <= S_FINISH;
          end else begin
            dreg  <= d_loss;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          product <= 64'(item.bytes_in_flight) * 64'(largest_qd);
          state   <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_done) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          thr   <= (q_clamped > floor2) ? q_clamped : floor2;
          state <= S_FINISH;
        end
        S_FINISH: begin
          // wait for the output register to free up
          if (!out_valid || !out_stall) begin
            out_valid                <= 1'b1;
            out_data.new_threshold   <= thr;
            out_data.max_queue_delay <= largest_qd;
            out_data.base_delay      <= base_min;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ODCT_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall)
  `ODCT_ASSERT_NOW(a_recent_bound, clk, rst, 1'b1, recent_used <= FUW'(FCAP))
  `ODCT_ASSERT_NOW(a_base_min_newest, clk, rst,
    (state == S_IDLE) && (base_used != '0), base_min <= base_last)
  `ODCT_ASSERT_NOW(a_div_done_wait, clk, rst, div_done, state == S_DIVWAIT)

endmodule
`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the one-way delay base tracking and loss threshold unit
`timescale 1ns / 1ps
module testbench;
  import odct_pkg::*;

  localparam int BASE_DEPTH   = 9;
  localparam int FILTER_DEPTH = 7;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int PHASE_ITEMS  = 375;

  // predicts the block and holds the results it still owes
  class threshold_board;
    logic [15:0] seg_size;
    logic [15:0] rollover_s;
    logic [31:0] base_hist[BASE_DEPTH];
    int          base_cnt;
    logic [31:0] recent_win[FILTER_DEPTH];
    int          recent_cnt;
    logic [31:0] peak_qd;
    logic [31:0] last_roll;
    logic        have_sample;
    odct_out_t   awaited[$];
    int          errors;

    function new();
      seg_size    = SEGMENT_SIZE_RST;
      rollover_s  = ROLLOVER_RST;
      base_cnt    = 0;
      recent_cnt  = 0;
      peak_qd     = '0;
      last_roll   = '0;
      have_sample = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_SEGMENT_SIZE: seg_size = val;
        REG_ROLLOVER: rollover_s = val;
        default: ;
      endcase
    endfunction

    function void push_recent(logic [31:0] v);
      if (recent_cnt >= FILTER_DEPTH) begin
        for (int i = 1; i < FILTER_DEPTH; i++) recent_win[i-1] = recent_win[i];
        recent_win[FILTER_DEPTH-1] = v;
      end else begin
        recent_win[recent_cnt] = v;
        recent_cnt++;
      end
    endfunction

    function void push_base(logic [31:0] v);
      if (base_cnt >= BASE_DEPTH) begin
        for (int i = 1; i < BASE_DEPTH; i++) base_hist[i-1] = base_hist[i];
        base_hist[BASE_DEPTH-1] = v;
      end else begin
        base_hist[base_cnt] = v;
        base_cnt++;
      end
    endfunction

    function logic [31:0] base_min();
      logic [31:0] m;
      m = '1;
      for (int i = 0; i < base_cnt; i++) if (base_hist[i] < m) m = base_hist[i];
      return m;
    endfunction

    function logic [31:0] recent_min();
      logic [31:0] m;
      m = '1;
      for (int i = 0; i < recent_cnt; i++) if (recent_win[i] < m) m = recent_win[i];
      return m;
    endfunction

    function logic [31:0] recent_max();
      logic [31:0] m;
      m = '0;
      for (int i = 0; i < recent_cnt; i++) if (recent_win[i] > m) m = recent_win[i];
      return m;
    endfunction

    function void note_item(odct_in_t it);
      odct_out_t   r;
      logic [31:0] owd, qd, d, floor2, half, elapsed;
      logic [63:0] q;
      r = '0;
      if (it.opcode == OP_ACK) begin
        have_sample = (it.ts_value != '0) && (it.ts_echo != '0);
        if (have_sample && it.rtt_positive) begin
          owd = it.ts_value - it.ts_echo;
          push_recent(owd);
          elapsed = it.now_seconds - last_roll;
          if (base_cnt == 0) begin
            // first base entry leaves the rollover time alone
            push_base(owd);
          end else if (elapsed > {16'd0, rollover_s}) begin
            last_roll = it.now_seconds;
            push_base(owd);
          end else if (owd < base_hist[base_cnt-1]) begin
            base_hist[base_cnt-1] = owd;
          end
          qd = recent_min() - base_min();
          if (qd > peak_qd) peak_qd = qd;
        end
      end else begin
        floor2 = {15'd0, seg_size, 1'b0};
        if (!have_sample || peak_qd == '0) begin
          half = it.bytes_in_flight >> 1;
          r.new_threshold = (half > floor2) ? half : floor2;
        end else begin
          d = recent_max() - base_min();
          if (d == '0) begin
            r.new_threshold = it.old_threshold;
          end else begin
            q = ({32'd0, it.bytes_in_flight} * {32'd0, peak_qd}) / {31'd0, d, 1'b0};
            if (q > {32'd0, it.old_threshold}) q = {32'd0, it.old_threshold};
            r.new_threshold = (q[31:0] > floor2) ? q[31:0] : floor2;
          end
        end
      end
      r.max_queue_delay = peak_qd;
      r.base_delay      = base_min();
      awaited = {awaited, r};
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
        errors++;
      end
    endfunction

    function void check_result(odct_out_t got);
      odct_out_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("new_threshold", want.new_threshold, got.new_threshold);
      compare_field("max_queue_delay", want.max_queue_delay, got.max_queue_delay);
      compare_field("base_delay", want.base_delay, got.base_delay);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  odct_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  odct_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  threshold_board board;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  logic [31:0] sim_now = '0;
  logic [31:0] owd_level = 32'd1000;
  logic [15:0] cur_rollover = ROLLOVER_RST;

  owd_delay_congestion_threshold_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("owd_delay_congestion_threshold_unit verification failed");
      $finish;
    end
  end

  // result side: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(odct_in_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    board.note_item(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_reg(idx, val);
    if (idx == REG_ROLLOVER) cur_rollover = val;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() > 0);
  endtask

  // knobs read by the result side change away from the clock edge
  task automatic set_knobs(int idle, int stall, int hold);
    @(negedge clk);
    idle_pct  = idle;
    stall_pct = stall;
    hold_left = hold;
    @(posedge clk);
  endtask

  task automatic do_ack(logic [31:0] tsv, logic [31:0] tse, logic rttp, logic [31:0] now);
    odct_in_t it;
    it.opcode          = OP_ACK;
    it.ts_value        = tsv;
    it.ts_echo         = tse;
    it.rtt_positive    = rttp;
    it.now_seconds     = now;
    it.bytes_in_flight = $urandom;
    it.old_threshold   = $urandom;
    send_item(it);
  endtask

  task automatic do_loss(logic [31:0] bif, logic [31:0] old);
    odct_in_t it;
    it.opcode          = OP_LOSS;
    it.ts_value        = $urandom;
    it.ts_echo         = $urandom;
    it.rtt_positive    = 1'($urandom_range(1));
    it.now_seconds     = $urandom;
    it.bytes_in_flight = bif;
    it.old_threshold   = old;
    send_item(it);
  endtask

  task automatic send_random();
    int          pick;
    logic [31:0] owd, tse, tsv, bif, old;
    pick = $urandom_range(99);
    if (pick < 20) begin
      bif = $urandom_range(1) ? $urandom : $urandom_range(200000);
      old = $urandom_range(1) ? $urandom : $urandom_range(300000);
      do_loss(bif, old);
    end else if (pick < 30) begin
      // noise: zero timestamps and arbitrary clock values
      tsv = $urandom_range(3) == 0 ? 32'd0 : $urandom;
      tse = $urandom_range(3) == 0 ? 32'd0 : $urandom;
      do_ack(tsv, tse, 1'($urandom_range(1)), $urandom);
    end else begin
      case ($urandom_range(9))
        0: sim_now = sim_now + $urandom_range(2 * cur_rollover + 2);
        1: sim_now = sim_now + $urandom;
        default: sim_now = sim_now + $urandom_range(3);
      endcase
      if ($urandom_range(15) == 0)
        owd_level = $urandom_range(1) ? $urandom : $urandom_range(1 << 20);
      owd = owd_level + $urandom_range(500);
      tse = $urandom;
      if (tse == '0) tse = 32'd1;
      tsv = tse + owd;
      if (tsv == '0) tsv = 32'd1;
      do_ack(tsv, tse, $urandom_range(9) != 0, sim_now);
    end
  endtask

  task automatic run_phase();
    repeat (PHASE_ITEMS) send_random();
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset defaults, no idling
    do_loss(32'hFFFF_FFFF, 32'd0);
    do_ack(32'd0, 32'd5, 1'b1, 32'd0);
    do_ack(32'd5, 32'd0, 1'b1, 32'd0);
    do_ack(32'd20, 32'd10, 1'b0, 32'd0);
    do_loss(32'd0, $urandom);
    do_ack(32'd1100, 32'd1000, 1'b1, 32'd0);
    // push the low sample out of the recent window to build a queue delay
    for (int i = 1; i <= 7; i++) do_ack(32'd2200, 32'd2000, 1'b1, 32'(i));
    do_loss(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // wrapped timestamps bring the recent maximum down to the base minimum
    for (int i = 8; i <= 14; i++) do_ack(32'h0000_0054, 32'hFFFF_FFF0, 1'b1, 32'(i));
    do_loss($urandom, $urandom);
    do_ack(32'd57, 32'd7, 1'b1, 32'd1000);
    do_ack(32'hFFFF_FFFF, 32'd1, 1'b1, 32'hFFFF_FFFF);
    do_loss(32'd10, 32'hFFFF_FFFF);
    drain_results();

    write_reg(REG_SEGMENT_SIZE, 16'd1);
    write_reg(REG_ROLLOVER, 16'd1);
    set_knobs(0, 0, 400);
    run_phase();
    drain_results();

    write_reg(REG_SEGMENT_SIZE, 16'hFFFF);
    write_reg(REG_ROLLOVER, 16'hFFFF);
    set_knobs(70, 0, 0);
    run_phase();
    drain_results();

    write_reg(REG_SEGMENT_SIZE, 16'($urandom_range(1, 65535)));
    write_reg(REG_ROLLOVER, 16'($urandom_range(1, 20)));
    set_knobs(0, 70, 0);
    run_phase();
    drain_results();

    write_reg(REG_SEGMENT_SIZE, SEGMENT_SIZE_RST);
    write_reg(REG_ROLLOVER, ROLLOVER_RST);
    set_knobs(12, 12, 0);
    run_phase();
    drain_results();

    repeat (80) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("owd_delay_congestion_threshold_unit verification clean");
    end else begin
      $display("owd_delay_congestion_threshold_unit verification failed");
    end
    $finish;
  end

endmodule
